// ===== rtl/motion_gated_imu_capture_defines.svh =====
// Assertion helpers shared by the capture block.
`ifndef MOTION_GATED_IMU_CAPTURE_DEFINES_SVH
`define MOTION_GATED_IMU_CAPTURE_DEFINES_SVH

// Invariant checked at every clock edge outside reset.
`define MGIC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies consequence in the next.
`define MGIC_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mgic_pkg.sv =====
package mgic_pkg;

    // Capture buffer depth; the sample counter saturates here.
    localparam int BUF_DEPTH = 1024;
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

    // Depth of the queue between classifier and state machine.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration register indexes.
    localparam logic [1:0] CFG_SENSOR_MODE  = 2'd0;
    localparam logic [1:0] CFG_GYRO_SCALE   = 2'd1;
    localparam logic [1:0] CFG_FIRST_SYMBOL = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_END   = 2'd1;
    localparam logic [1:0] ST_FIRST = 2'd2;
    localparam logic [1:0] ST_CONT  = 2'd3;

    // round(m/327) half away from zero == floor((m+163)/327) (no exact half).
    // floor(x/327) == (x*51307) >> 24 for x < 2^24/173.
    localparam logic [15:0] ACC_BIAS  = 16'd163;
    localparam logic [15:0] ACC_MUL   = 16'd51307;
    localparam int          ACC_SHIFT = 24;
    // round(m/10) == floor((m+5)/10) == ((m+5)*52429) >> 19 for m+5 < 2^18.
    localparam logic [15:0] GYR_BIAS  = 16'd5;
    localparam logic [15:0] GYR_MUL   = 16'd52429;
    localparam int          GYR_SHIFT = 19;

    localparam logic signed [15:0] ACC_TH = 16'sd4;
    localparam logic signed [15:0] GYR_TH = 16'sd40;

    typedef struct packed {
        logic        sensor_mode;
        logic        gyro_scale_enable;
        logic [15:0] first_symbol_number;
    } t_cfg;

    typedef struct packed {
        logic               trigger;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
    } t_in;

    // Classified sample passed from front to back.
    typedef struct packed {
        logic               trigger;
        logic               moving;
        logic signed [15:0] level_x;
        logic signed [15:0] level_y;
        logic signed [15:0] level_z;
    } t_cls;

    typedef struct packed {
        logic [1:0]         status;
        logic               stored;
        logic signed [15:0] level_x;
        logic signed [15:0] level_y;
        logic signed [15:0] level_z;
        logic [10:0]        sample_index;
        logic [15:0]        symbol_number;
    } t_out;

    // Queue status seen by the back end.
    typedef struct packed {
        logic        valid;
        logic [QCNT_W-1:0] count;
    } t_qstat;

endpackage

// ===== rtl/motion_gated_imu_capture.sv =====
// Motion-gated three-axis IMU capture.
// Input side is a queue: drive i_item and raise push; the sample transaction
// is taken at a clock edge with push high and full low. Each sample carries
// the record trigger and three signed axis values.
// Result side is a queue too: while empty is low, o_result holds the oldest
// result; pop high at a clock edge takes it. Every sample gives one result.
// A taken sample is loaded into the multiply stage, classified into the mid
// queue, then written by the state update into the output buffer. Throughput
// is one sample per cycle while pop keeps the output buffer from filling,
// limited by the single state update in the back end; the front pipeline
// and the multiply per axis are fully pipelined.
// When pop stays low the two-entry output buffer fills, the back end stops
// draining the four-entry mid queue, and full rises once queued plus
// in-flight samples reach the queue depth; nothing is dropped.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx at once
// (0 sensor mode, 1 gyro scale enable, 2 first symbol number); write only
// while no samples are pending. Synchronous reset clears the registers,
// the capture state, the symbol count and both queues.
module motion_gated_imu_capture import mgic_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_in         i_item,
    output logic        empty,
    input  logic        pop,
    output t_out        o_result,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    t_cfg   r_cfg;
    t_cfg   n_cfg;

    logic   w_accept;
    logic   w_fpush;
    logic   w_fbusy;
    t_cls   w_fcls;
    t_cls   w_qhead;
    t_qstat w_qstat;
    logic   w_qpop;
    logic [QCNT_W:0] w_pending;

    // Config register file.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SENSOR_MODE:  n_cfg.sensor_mode         = i_cfg_data[0];
                CFG_GYRO_SCALE:   n_cfg.gyro_scale_enable   = i_cfg_data[0];
                CFG_FIRST_SYMBOL: n_cfg.first_symbol_number = i_cfg_data;
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Reserve a mid-queue slot for every sample still in the front pipeline.
    assign w_pending = {1'b0, w_qstat.count} + (QCNT_W+1)'(w_fbusy);
    assign full      = (w_pending >= (QCNT_W+1)'(QDEPTH));
    assign w_accept  = push && !full;

    mgic_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_accept (w_accept),
        .i_item   (i_item),
        .o_push   (w_fpush),
        .o_cls    (w_fcls),
        .o_busy   (w_fbusy)
    );

    mgic_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_fpush),
        .i_data   (w_fcls),
        .i_pop    (w_qpop),
        .o_head   (w_qhead),
        .o_stat   (w_qstat)
    );

    mgic_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_qstat  (w_qstat),
        .i_head   (w_qhead),
        .o_qpop   (w_qpop),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_result (o_result)
    );

endmodule

// ===== rtl/mgic_front.sv =====
module mgic_front import mgic_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_accept,
    input  t_in  i_item,
    output logic o_push,
    output t_cls o_cls,
    output logic o_busy
);

    logic               r_v1;
    logic               r_trig1;
    logic [2:0]         r_neg1;
    logic [31:0]        r_prod1 [3];
    logic [15:0]        r_raw1  [3];

    logic [15:0]        w_raw  [3];
    logic [15:0]        w_mag  [3];
    logic [15:0]        w_x    [3];
    logic [31:0]        w_prod [3];
    logic [11:0]        w_q    [3];
    logic [15:0]        w_qq   [3];
    logic signed [15:0] w_lv   [3];
    logic signed [15:0] w_th;
    logic               w_moving;

    assign w_raw[0] = i_item.axis_x;
    assign w_raw[1] = i_item.axis_y;
    assign w_raw[2] = i_item.axis_z;

    // Stage 1: magnitude, rounding bias, reciprocal multiply.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i]  = w_raw[i][15] ? (~w_raw[i] + 16'd1) : w_raw[i];
            w_x[i]    = w_mag[i] + (i_cfg.sensor_mode ? GYR_BIAS : ACC_BIAS);
            w_prod[i] = 32'(w_x[i]) * 32'(i_cfg.sensor_mode ? GYR_MUL : ACC_MUL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_trig1 <= i_item.trigger;
        for (int i = 0; i < 3; i++) begin
            r_neg1[i]  <= w_raw[i][15];
            r_prod1[i] <= w_prod[i];
            r_raw1[i]  <= w_raw[i];
        end
    end

    // Stage 2: quotient, sign, raw bypass, dead-zone test.
    assign w_th = i_cfg.sensor_mode ? GYR_TH : ACC_TH;

    always_comb begin
        w_moving = 1'b0;
        for (int i = 0; i < 3; i++) begin
            w_q[i]  = i_cfg.sensor_mode ? 12'(r_prod1[i] >> GYR_SHIFT)
                                        : 12'(r_prod1[i] >> ACC_SHIFT);
            w_qq[i] = {4'b0, w_q[i]};
            if (i_cfg.sensor_mode && !i_cfg.gyro_scale_enable) begin
                w_lv[i] = r_raw1[i];
            end else begin
                w_lv[i] = r_neg1[i] ? (~w_qq[i] + 16'd1) : w_qq[i];
            end
            if ((w_lv[i] > w_th) || (w_lv[i] < -w_th)) begin
                w_moving = 1'b1;
            end
        end
    end

    assign o_push          = r_v1;
    assign o_busy          = r_v1;
    assign o_cls.trigger   = r_trig1;
    assign o_cls.moving    = w_moving;
    assign o_cls.level_x   = w_lv[0];
    assign o_cls.level_y   = w_lv[1];
    assign o_cls.level_z   = w_lv[2];

endmodule

// ===== rtl/mgic_queue.sv =====
`include "motion_gated_imu_capture_defines.svh"

module mgic_queue import mgic_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_cls   i_data,
    input  logic   i_pop,
    output t_cls   o_head,
    output t_qstat o_stat
);

    t_cls              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              w_pop;

    assign w_pop = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_head       = r_mem[r_rd];
    assign o_stat.valid = (r_cnt != '0);
    assign o_stat.count = r_cnt;

    `MGIC_ASSERT(a_q_no_overflow, i_clk, i_rst_n, !(i_push && !w_pop && (r_cnt == QCNT_W'(QDEPTH))), "mid queue overflow")

endmodule

// ===== rtl/mgic_back.sv =====
`include "motion_gated_imu_capture_defines.svh"

module mgic_back import mgic_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  t_qstat i_qstat,
    input  t_cls   i_head,
    output logic   o_qpop,
    input  logic   i_pop,
    output logic   o_empty,
    output t_out   o_result
);

    logic             r_active;
    logic [CNT_W-1:0] r_cnt;
    logic [15:0]      r_done;
    logic             n_active;
    logic [CNT_W-1:0] n_cnt;
    logic [15:0]      n_done;

    t_out             r_obuf [2];
    logic             r_owr;
    logic             r_ord;
    logic [1:0]       r_ocnt;

    logic             w_take;
    logic             w_opop;
    logic [CNT_W-1:0] w_base;
    t_out             w_res;

    assign w_take = i_qstat.valid && (r_ocnt != 2'd2);
    assign w_opop = i_pop && (r_ocnt != 2'd0);
    assign o_qpop = w_take;

    always_comb begin
        n_active      = r_active;
        n_cnt         = r_cnt;
        n_done        = r_done;
        w_base        = r_active ? r_cnt : '0;
        w_res.stored  = 1'b0;
        w_res.level_x = '0;
        w_res.level_y = '0;
        w_res.level_z = '0;
        if (!i_head.trigger) begin
            if (r_active) begin
                n_active     = 1'b0;
                n_done       = r_done + 16'd1;
                w_res.status = ST_END;
            end else begin
                w_res.status = ST_IDLE;
            end
        end else begin
            n_active      = 1'b1;
            w_res.status  = r_active ? ST_CONT : ST_FIRST;
            w_res.level_x = i_head.level_x;
            w_res.level_y = i_head.level_y;
            w_res.level_z = i_head.level_z;
            // Saturate at buffer depth.
            w_res.stored  = i_head.moving && (w_base < CNT_W'(BUF_DEPTH));
            n_cnt         = w_base + CNT_W'(w_res.stored);
        end
        w_res.sample_index  = 11'(n_cnt);
        w_res.symbol_number = i_cfg.first_symbol_number + n_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt    <= '0;
            r_done   <= '0;
            r_owr    <= 1'b0;
            r_ord    <= 1'b0;
            r_ocnt   <= 2'd0;
        end else begin
            if (w_take) begin
                r_active <= n_active;
                r_cnt    <= n_cnt;
                r_done   <= n_done;
                r_owr    <= ~r_owr;
            end
            if (w_opop) begin
                r_ord <= ~r_ord;
            end
            r_ocnt <= r_ocnt + 2'(w_take) - 2'(w_opop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_obuf[r_owr] <= w_res;
        end
    end

    assign o_empty  = (r_ocnt == 2'd0);
    assign o_result = r_obuf[r_ord];

    `MGIC_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CNT_W'(BUF_DEPTH), "sample count above depth")
    `MGIC_ASSERT(a_obuf_bound, i_clk, i_rst_n, r_ocnt != 2'd3, "output buffer over two entries")
    `MGIC_ASSERT_NEXT(a_end_idle, i_clk, i_rst_n, w_take && !i_head.trigger, !r_active, "capture still active after release")

endmodule
